>>> sv/ssc_pkg.sv
`default_nettype none

package ssc_pkg;

	// Data flag value that marks a header for examination.
	localparam logic [7:0] FLAG_DATA = 8'd1;

	// Radial status codes.
	localparam logic [7:0] STAT_ELEV_END   = 8'd0;
	localparam logic [7:0] STAT_MIDDLE     = 8'd1;
	localparam logic [7:0] STAT_ELEV_START = 8'd2;
	localparam logic [7:0] STAT_VOL_START  = 8'd3;
	localparam logic [7:0] STAT_VOL_END    = 8'd4;

	// One radial header as held in the input register.
	typedef struct packed {
		logic       last_header;
		logic [7:0] elevation_number;
		logic [7:0] azimuth_status;
		logic [7:0] data_flag;
	} hdr_t;

	// One volume result.
	typedef struct packed {
		logic       scan_valid;
		logic [7:0] elevation_count;
	} res_t;

endpackage : ssc_pkg

`default_nettype wire

>>> sv/ssc_check.sv
`default_nettype none

module ssc_check (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        en,
	input  wire ssc_pkg::hdr_t hdr,
	output ssc_pkg::res_t    res,
	output logic             res_valid
);
	import ssc_pkg::*;

	// Sequence state: the last examined header, its predecessor and the flags.
	logic [7:0] cur_stat_q, cur_elev_q, prev_stat_q, prev_elev_q;
	logic       cur_pres_q, prev_pres_q, shift_q, start_q, end_q, err_q;

	logic [7:0] cur_stat_n, cur_elev_n, prev_stat_n, prev_elev_n;
	logic       cur_pres_n, prev_pres_n, shift_n, start_n, end_n, err_n;
	logic       examined, valid;
	logic [8:0] prev_elev_inc;

	assign examined      = (hdr.data_flag == FLAG_DATA) && (hdr.azimuth_status != STAT_MIDDLE);
	assign prev_elev_inc = {1'b0, prev_elev_n} + 9'd1;

	// Update of the sequence state for one header, checks against the predecessor.
	always_comb begin
		cur_stat_n  = cur_stat_q;
		cur_elev_n  = cur_elev_q;
		cur_pres_n  = cur_pres_q;
		prev_stat_n = prev_stat_q;
		prev_elev_n = prev_elev_q;
		prev_pres_n = prev_pres_q;
		shift_n     = shift_q;
		start_n     = start_q;
		end_n       = end_q;
		err_n       = err_q;
		if (examined) begin
			if (shift_q) begin
				prev_stat_n = cur_stat_q;
				prev_elev_n = cur_elev_q;
				prev_pres_n = cur_pres_q;
			end
			shift_n    = 1'b1;
			cur_stat_n = hdr.azimuth_status;
			cur_elev_n = hdr.elevation_number;
			cur_pres_n = 1'b1;
			case (hdr.azimuth_status)
				STAT_ELEV_END: begin
					if (!prev_pres_n || prev_stat_n != STAT_ELEV_START ||
					    prev_elev_inc != {1'b0, hdr.elevation_number})
						err_n = 1'b1;
				end
				STAT_ELEV_START: begin
					if (!prev_pres_n || !(prev_stat_n inside {STAT_ELEV_END, STAT_VOL_START}) ||
					    prev_elev_n != hdr.elevation_number)
						err_n = 1'b1;
				end
				STAT_VOL_START: begin
					if (prev_pres_n)
						err_n = 1'b1;
					start_n = 1'b1;
				end
				STAT_VOL_END: begin
					if (!prev_pres_n || prev_stat_n != STAT_ELEV_END ||
					    prev_elev_n != hdr.elevation_number)
						err_n = 1'b1;
					end_n = 1'b1;
				end
				default: begin
					shift_n = 1'b0;
				end
			endcase
		end
	end

	// Volume result, formed on the final header.
	assign valid               = !err_n && start_n && end_n && (hdr.azimuth_status == STAT_VOL_END);
	assign res.scan_valid      = valid;
	assign res.elevation_count = valid ? cur_elev_n : 8'd0;
	assign res_valid           = en && hdr.last_header;

	// State registers; the final header returns everything to its reset value.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_stat_q  <= 8'd0;
			cur_elev_q  <= 8'd0;
			cur_pres_q  <= 1'b0;
			prev_stat_q <= 8'd0;
			prev_elev_q <= 8'd0;
			prev_pres_q <= 1'b0;
			shift_q     <= 1'b1;
			start_q     <= 1'b0;
			end_q       <= 1'b0;
			err_q       <= 1'b0;
		end else if (en) begin
			if (hdr.last_header) begin
				cur_stat_q  <= 8'd0;
				cur_elev_q  <= 8'd0;
				cur_pres_q  <= 1'b0;
				prev_stat_q <= 8'd0;
				prev_elev_q <= 8'd0;
				prev_pres_q <= 1'b0;
				shift_q     <= 1'b1;
				start_q     <= 1'b0;
				end_q       <= 1'b0;
				err_q       <= 1'b0;
			end else begin
				cur_stat_q  <= cur_stat_n;
				cur_elev_q  <= cur_elev_n;
				cur_pres_q  <= cur_pres_n;
				prev_stat_q <= prev_stat_n;
				prev_elev_q <= prev_elev_n;
				prev_pres_q <= prev_pres_n;
				shift_q     <= shift_n;
				start_q     <= start_n;
				end_q       <= end_n;
				err_q       <= err_n;
			end
		end
	end

endmodule : ssc_check

`default_nettype wire

>>> sv/scan_sequence_checker_core.sv
// Channel  Dir  tdata (low bit up)                                  tuser       tlast
// s_       in   data_flag[7:0] azimuth_status[15:8] elev[23:16]       -           last_header
// m_       out  elevation_count[7:0]                                scan_valid  -
//
// One header is accepted per cycle unless the input register stalls; a result leaves through the output register.
// Every examined header is checked combinationally between the input register and the state.
// Reset is asynchronous and active low; it clears the sequence state and both valid flags.
// The input register stalls only while a result waits in the output register untaken.
`default_nettype none

module scan_sequence_checker_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [23:0] s_tdata,  // data_flag, azimuth_status, elevation_number
	input  wire logic        s_tlast,  // last_header
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]       m_tdata,  // elevation_count
	output logic             m_tuser   // scan_valid
);
	import ssc_pkg::*;

	hdr_t hdr_s1;
	logic vld_s1;
	logic adv;
	res_t res, res_q;
	logic res_valid;
	logic out_vld_q;

	// The input register moves on unless a held result blocks the output register.
	assign adv      = vld_s1 && !(out_vld_q && !m_tready);
	assign s_tready = !vld_s1 || adv;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			hdr_s1.data_flag        <= s_tdata[7:0];
			hdr_s1.azimuth_status   <= s_tdata[15:8];
			hdr_s1.elevation_number <= s_tdata[23:16];
			hdr_s1.last_header      <= s_tlast;
		end
	end

	// Sequence checker.
	ssc_check u_check (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.hdr      (hdr_s1),
		.res      (res),
		.res_valid(res_valid)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (res_valid) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			res_q <= res;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = res_q.elevation_count;
	assign m_tuser  = res_q.scan_valid;

`ifndef SYNTHESIS
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!vld_s1 |-> s_tready)
		else $error("input register empty but not ready");
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && hdr_s1.last_header) |=> m_tvalid)
		else $error("final header gave no result");
	a_no_adv_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && !m_tready) |-> !adv)
		else $error("header processed while result blocked");
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser) |-> (m_tdata == 8'd0))
		else $error("invalid result carries an elevation");
`endif

endmodule : scan_sequence_checker_core

`default_nettype wire
